// ===== rtl/afad_pkg.sv =====
// shared types and constants for the fault address decoder
package afad_pkg;

  localparam logic [31:0] ARM_SWP_MASK  = 32'h0FB0_0FF0;
  localparam logic [31:0] ARM_SWP_VAL   = 32'h0100_0090;
  localparam logic [31:0] ARM_LS_MASK   = 32'h0C00_0000;
  localparam logic [31:0] ARM_LS_VAL    = 32'h0400_0000;
  localparam logic [31:0] ARM_HW_MASK   = 32'h0E40_0F90;
  localparam logic [31:0] ARM_HWR_VAL   = 32'h0000_0090;
  localparam logic [31:0] ARM_HWI_VAL   = 32'h0040_0090;
  localparam logic [31:0] ARM_LSM_MASK  = 32'h0E00_0000;
  localparam logic [31:0] ARM_LSM_VAL   = 32'h0800_0000;
  localparam logic [7:0]  SHIFT_NONE    = 8'h0B;

  localparam logic [15:0] TH_F800_MASK  = 16'hF800;
  localparam logic [15:0] TH_F200_MASK  = 16'hF200;
  localparam logic [15:0] TH_F000_MASK  = 16'hF000;
  localparam logic [15:0] TH_E000_MASK  = 16'hE000;
  localparam logic [15:0] TH_F700_MASK  = 16'hF700;
  localparam logic [15:0] TH_LDR_PC     = 16'h4800;
  localparam logic [15:0] TH_REG_A      = 16'h5000;
  localparam logic [15:0] TH_REG_B      = 16'h5200;
  localparam logic [15:0] TH_IMM_A      = 16'h6000;
  localparam logic [15:0] TH_IMM_B      = 16'h8000;
  localparam logic [15:0] TH_SP_REL     = 16'h9000;
  localparam logic [15:0] TH_PUSH_POP   = 16'hB500;
  localparam logic [15:0] TH_LDM_STM    = 16'hC000;

  localparam logic [3:0]  REG_SP        = 4'd13;
  localparam logic [3:0]  REG_PC        = 4'd15;

  typedef enum logic [2:0] {
    ALU_LSL,
    ALU_LSR,
    ALU_ASR,
    ALU_ROR,
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_BASE,
    ST_RD_OFF,
    ST_RD_RS,
    ST_SHIFT,
    ST_ADD
  } state_e;

  typedef struct packed {
    logic        matched;
    logic [3:0]  base_idx;
    logic        off_from_reg;
    logic [3:0]  off_idx;
    logic [31:0] imm;
    logic        do_shift;
    logic        shift_by_reg;
    logic [3:0]  rs_idx;
    logic [4:0]  shift_amt;
    alu_op_e     shift_op;
    logic        subtract;
  } plan_t;

endpackage

// ===== rtl/afad_decode.sv =====
// opcode decoder: turns an arm or thumb load/store word into an address plan
module afad_decode (
  input  logic [31:0]   opcode_i,
  input  logic          thumb_i,
  output afad_pkg::plan_t plan_o
);
  import afad_pkg::*;

  logic [15:0] op16;
  logic [7:0]  shcode;

  assign op16   = opcode_i[15:0];
  assign shcode = opcode_i[11:4];

  always_comb begin
    plan_o              = '0;
    plan_o.shift_op     = ALU_LSL;
    plan_o.base_idx     = opcode_i[19:16];
    plan_o.off_idx      = opcode_i[3:0];
    plan_o.rs_idx       = shcode[7:4];
    plan_o.shift_amt    = shcode[7:3];
    plan_o.shift_by_reg = shcode[0];
    if (thumb_i) begin
      if ((op16 & TH_F800_MASK) == TH_LDR_PC) begin
        plan_o.matched  = 1'b1;
        plan_o.base_idx = REG_PC;
        plan_o.imm      = {{24{op16[7]}}, op16[7:0]};
      end else if ((op16 & TH_F200_MASK) == TH_REG_A ||
                   (op16 & TH_F200_MASK) == TH_REG_B) begin
        plan_o.matched      = 1'b1;
        plan_o.base_idx     = {1'b0, op16[5:3]};
        plan_o.off_from_reg = 1'b1;
        plan_o.off_idx      = {1'b0, op16[8:6]};
      end else if ((op16 & TH_E000_MASK) == TH_IMM_A ||
                   (op16 & TH_F000_MASK) == TH_IMM_B) begin
        plan_o.matched  = 1'b1;
        plan_o.base_idx = {1'b0, op16[5:3]};
        plan_o.imm      = {25'd0, op16[10:6], 2'b00};
      end else if ((op16 & TH_F000_MASK) == TH_SP_REL) begin
        plan_o.matched  = 1'b1;
        plan_o.base_idx = REG_SP;
        plan_o.imm      = {{24{op16[7]}}, op16[7:0]};
      end else if ((op16 & TH_F700_MASK) == TH_PUSH_POP) begin
        plan_o.matched  = 1'b1;
        plan_o.base_idx = REG_SP;
      end else if ((op16 & TH_F000_MASK) == TH_LDM_STM) begin
        plan_o.matched  = 1'b1;
        plan_o.base_idx = {1'b0, op16[10:8]};
      end
    end else begin
      if ((opcode_i & ARM_SWP_MASK) == ARM_SWP_VAL) begin
        plan_o.matched = 1'b1;
      end else if ((opcode_i & ARM_LS_MASK) == ARM_LS_VAL) begin
        plan_o.matched = 1'b1;
        // post-index forms only need the base
        if (opcode_i[24]) begin
          plan_o.subtract = !opcode_i[23];
          if (opcode_i[25]) begin
            plan_o.off_from_reg = 1'b1;
            plan_o.do_shift     = (shcode != SHIFT_NONE);
            unique case (shcode[2:1])
              2'd0:    plan_o.shift_op = ALU_LSL;
              2'd1:    plan_o.shift_op = ALU_LSR;
              2'd2:    plan_o.shift_op = ALU_ASR;
              default: plan_o.shift_op = ALU_ROR;
            endcase
          end else begin
            plan_o.imm = {20'd0, opcode_i[11:0]};
          end
        end
      end else if ((opcode_i & ARM_HW_MASK) == ARM_HWR_VAL) begin
        plan_o.matched      = 1'b1;
        plan_o.subtract     = !opcode_i[23];
        plan_o.off_from_reg = 1'b1;
      end else if ((opcode_i & ARM_HW_MASK) == ARM_HWI_VAL) begin
        plan_o.matched  = 1'b1;
        plan_o.subtract = !opcode_i[23];
        plan_o.imm      = {24'd0, opcode_i[11:8], opcode_i[3:0]};
      end else if ((opcode_i & ARM_LSM_MASK) == ARM_LSM_VAL) begin
        plan_o.matched = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/afad_regfile.sv =====
// saved register file: one write port, one registered read port, valid bits
module afad_regfile (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        we_i,
  input  logic [3:0]  waddr_i,
  input  logic [31:0] wdata_i,
  input  logic [3:0]  raddr_i,
  output logic [31:0] rdata_o
);
  import afad_pkg::*;

  logic [31:0] mem [16];
  logic [15:0] valid_q;
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i) begin
    rdata_q <= valid_q[raddr_i] ? mem[raddr_i] : 32'd0;
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/afad_alu.sv =====
// shared shift and add/subtract unit
module afad_alu (
  input  afad_pkg::alu_op_e op_i,
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  input  logic [31:0]       amt_i,
  output logic [31:0]       y_o
);
  import afad_pkg::*;

  logic       big;
  logic [4:0] n;

  assign big = (amt_i[31:5] != 27'd0);
  assign n   = amt_i[4:0];

  always_comb begin
    unique case (op_i)
      ALU_LSL: y_o = big ? 32'd0 : (a_i << n);
      ALU_LSR: y_o = big ? 32'd0 : (a_i >> n);
      ALU_ASR: y_o = big ? {32{a_i[31]}} : 32'($signed(a_i) >>> n);
      // rotate uses the amount modulo 32
      ALU_ROR: y_o = (n == 5'd0) ? a_i : ((a_i >> n) | (a_i << (6'd32 - {1'b0, n})));
      ALU_ADD: y_o = a_i + b_i;
      ALU_SUB: y_o = a_i - b_i;
      default: y_o = a_i;
    endcase
  end

endmodule

// ===== rtl/arm_fault_address_decoder_unit.sv =====
// top level: sequencer around the saved register file and the shared alu
//
// Input channel (in_valid_i / in_stall_o) carries one word: action, reg_index,
// reg_value, opcode, thumb. A write word (action 0) loads one saved register
// and gives no result; the block takes the next word in the following cycle.
// A resolve word (action 1) gives one result word (fault_address, matched) on
// the output channel (out_valid_o / out_stall_i).
// A resolve holds the input stalled until the sequencer is idle again. Its
// steps are set by the single registered read port of the register file
// (base, offset and shift amount read in turn) followed by one shift pass
// and one add pass through the shared alu.
// The result sits in an output register; new words are taken while it waits.
// If the receiver stalls and a second result is ready, the sequencer holds in
// its last step until the output register frees.
// Reset makes all saved registers read zero and empties the output register.
module arm_fault_address_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [3:0]  reg_index_i,
  input  logic [31:0] reg_value_i,
  input  logic [31:0] opcode_i,
  input  logic        thumb_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] fault_address_o,
  output logic        matched_o
);
  import afad_pkg::*;

  state_e      state_q, state_d;
  plan_t       plan_dec;
  plan_t       plan_q;
  logic [31:0] base_q, base_d;
  logic [31:0] off_q, off_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] addr_q, addr_d;
  logic        matched_q, matched_d;
  logic        accept;
  logic        rf_we;
  logic [3:0]  rf_raddr;
  logic [31:0] rf_rdata;
  alu_op_e     alu_op;
  logic [31:0] alu_a, alu_b, alu_amt, alu_y;

  afad_decode u_decode (
    .opcode_i (opcode_i),
    .thumb_i  (thumb_i),
    .plan_o   (plan_dec)
  );

  afad_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (rf_we),
    .waddr_i (reg_index_i),
    .wdata_i (reg_value_i),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata)
  );

  afad_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .amt_i (alu_amt),
    .y_o   (alu_y)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign rf_we      = accept && !action_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      plan_q <= plan_dec;
    end
    base_q    <= base_d;
    off_q     <= off_d;
    addr_q    <= addr_d;
    matched_q <= matched_d;
  end

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    off_d       = off_q;
    addr_d      = addr_q;
    matched_d   = matched_q;
    out_valid_d = out_valid_q && out_stall_i;
    rf_raddr    = plan_q.base_idx;
    alu_op      = plan_q.shift_op;
    alu_a       = off_q;
    alu_b       = off_q;
    alu_amt     = plan_q.shift_by_reg ? rf_rdata : {27'd0, plan_q.shift_amt};
    unique case (state_q)
      ST_IDLE: begin
        if (accept && action_i) begin
          state_d = ST_RD_BASE;
        end
      end
      ST_RD_BASE: begin
        rf_raddr = plan_q.base_idx;
        state_d  = ST_RD_OFF;
      end
      ST_RD_OFF: begin
        rf_raddr = plan_q.off_idx;
        base_d   = rf_rdata;
        state_d  = ST_RD_RS;
      end
      ST_RD_RS: begin
        rf_raddr = plan_q.rs_idx;
        off_d    = plan_q.off_from_reg ? rf_rdata : plan_q.imm;
        state_d  = ST_SHIFT;
      end
      ST_SHIFT: begin
        // rf_rdata now holds the shift amount register
        if (plan_q.do_shift) begin
          off_d = alu_y;
        end
        state_d = ST_ADD;
      end
      ST_ADD: begin
        alu_op = plan_q.subtract ? ALU_SUB : ALU_ADD;
        alu_a  = base_q;
        alu_b  = off_q;
        if (!out_valid_q || !out_stall_i) begin
          addr_d      = plan_q.matched ? alu_y : 32'd0;
          matched_d   = plan_q.matched;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign fault_address_o = addr_q;
  assign matched_o       = matched_q;

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !action_i) |=> !$rose(out_valid_o))
    else $error("write word produced a result");

  a_resolve_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i) |=> in_stall_o)
    else $error("sequencer not busy after resolve word");

  a_unmatched_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !matched_o) |-> (fault_address_o == 32'd0))
    else $error("unmatched result with nonzero address");

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for the arm/thumb fault address decoder
module testbench;
  import afad_pkg::*;

  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_RESOLVE = 1'b1;
  localparam int   RANDOM_WORDS = 775;
  localparam int   QUIET_TAIL   = 100;
  localparam int   HOLD_AT      = 120;
  localparam int   HOLD_LEN     = 200;
  localparam int   DRAIN_CYCLES = 12;
  localparam int   LIMIT_CYCLES = 300000;

  typedef struct packed {
    logic        action;
    logic [3:0]  reg_index;
    logic [31:0] reg_value;
    logic [31:0] opcode;
    logic        thumb;
  } word_t;

  typedef struct packed {
    logic [31:0] addr;
    logic        matched;
  } fault_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        action_i = 1'b0;
  logic [3:0]  reg_index_i = '0;
  logic [31:0] reg_value_i = '0;
  logic [31:0] opcode_i = '0;
  logic        thumb_i = 1'b0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [31:0] fault_address_o;
  logic        matched_o;

  word_t       pending_words[$];
  fault_t      expected_results[$];
  logic [31:0] shadow_regs[16];
  int          words_taken = 0;
  int          quiet_from = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_cycles = 0;
  logic        hold_started = 1'b0;
  int          mismatches = 0;
  wire         calm = (words_taken >= quiet_from) || (((words_taken >> 6) % 4) == 3);

  arm_fault_address_decoder_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .reg_index_i     (reg_index_i),
    .reg_value_i     (reg_value_i),
    .opcode_i        (opcode_i),
    .thumb_i         (thumb_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .fault_address_o (fault_address_o),
    .matched_o       (matched_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic fault_t resolve_fault(logic [31:0] op, logic thumb);
    fault_t      res;
    logic [31:0] base;
    logic [31:0] off;
    logic [31:0] val;
    logic [31:0] amt;
    logic [15:0] t;
    logic [7:0]  code;
    logic [4:0]  rot;
    logic        offset_used;
    res.addr = 32'd0;
    res.matched = 1'b1;
    offset_used = 1'b0;
    off = 32'd0;
    base = shadow_regs[op[19:16]];
    t = op[15:0];
    if (thumb) begin
      if ((t & TH_F800_MASK) == TH_LDR_PC)
        res.addr = shadow_regs[REG_PC] + {{24{t[7]}}, t[7:0]};
      else if ((t & TH_F200_MASK) == TH_REG_A || (t & TH_F200_MASK) == TH_REG_B)
        res.addr = shadow_regs[{1'b0, t[5:3]}] + shadow_regs[{1'b0, t[8:6]}];
      else if ((t & TH_E000_MASK) == TH_IMM_A || (t & TH_F000_MASK) == TH_IMM_B)
        res.addr = shadow_regs[{1'b0, t[5:3]}] + {25'd0, t[10:6], 2'b00};
      else if ((t & TH_F000_MASK) == TH_SP_REL)
        res.addr = shadow_regs[REG_SP] + {{24{t[7]}}, t[7:0]};
      else if ((t & TH_F700_MASK) == TH_PUSH_POP)
        res.addr = shadow_regs[REG_SP];
      else if ((t & TH_F000_MASK) == TH_LDM_STM)
        res.addr = shadow_regs[{1'b0, t[10:8]}];
      else
        res.matched = 1'b0;
    end else if ((op & ARM_SWP_MASK) == ARM_SWP_VAL) begin
      res.addr = base;
    end else if ((op & ARM_LS_MASK) == ARM_LS_VAL) begin
      if (!op[24]) begin
        // post-index: the base itself is accessed
        res.addr = base;
      end else begin
        offset_used = 1'b1;
        if (!op[25]) begin
          off = {20'd0, op[11:0]};
        end else begin
          val = shadow_regs[op[3:0]];
          code = op[11:4];
          amt = code[0] ? shadow_regs[code[7:4]] : {27'd0, code[7:3]};
          rot = amt[4:0];
          if (code == SHIFT_NONE) begin
            off = val;
          end else begin
            case (code[2:1])
              2'd0: off = (amt >= 32) ? 32'd0 : val << amt;
              2'd1: off = (amt >= 32) ? 32'd0 : val >> amt;
              2'd2: begin
                if (amt >= 32) off = {32{val[31]}};
                else off = $signed(val) >>> amt;
              end
              default: off = (rot == 5'd0) ? val : ((val >> rot) | (val << (6'd32 - rot)));
            endcase
          end
        end
      end
    end else if ((op & ARM_HW_MASK) == ARM_HWR_VAL) begin
      offset_used = 1'b1;
      off = shadow_regs[op[3:0]];
    end else if ((op & ARM_HW_MASK) == ARM_HWI_VAL) begin
      offset_used = 1'b1;
      off = {24'd0, op[11:8], op[3:0]};
    end else if ((op & ARM_LSM_MASK) == ARM_LSM_VAL) begin
      res.addr = base;
    end else begin
      res.matched = 1'b0;
    end
    if (offset_used) res.addr = op[23] ? base + off : base - off;
    return res;
  endfunction

  task automatic queue_write(logic [3:0] idx, logic [31:0] value);
    word_t w;
    w.action = ACT_WRITE;
    w.reg_index = idx;
    w.reg_value = value;
    w.opcode = $urandom;
    w.thumb = 1'($urandom_range(0, 1));
    pending_words.push_back(w);
  endtask

  task automatic queue_resolve(logic [31:0] op, logic thumb);
    word_t w;
    w.action = ACT_RESOLVE;
    w.reg_index = 4'($urandom_range(0, 15));
    w.reg_value = $urandom;
    w.opcode = op;
    w.thumb = thumb;
    pending_words.push_back(w);
  endtask

  task automatic log_mismatch(string msg);
    if (mismatches < 10) $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // driver: holds each word until taken, predicts results at acceptance
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    word_t w;
    logic  take;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
      words_taken <= 0;
    end else begin
      take = in_valid_i && !in_stall_o;
      if (take) begin
        words_taken <= words_taken + 1;
        if (action_i == ACT_WRITE) shadow_regs[reg_index_i] = reg_value_i;
        else expected_results.push_back(resolve_fault(opcode_i, thumb_i));
      end
      if (!in_valid_i || take) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!calm && hold_cycles == 0 && $urandom_range(0, 11) == 0) begin
          send_gap <= $urandom_range(0, 12);
          in_valid_i <= 1'b0;
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          in_valid_i <= 1'b1;
          action_i <= w.action;
          reg_index_i <= w.reg_index;
          reg_value_i <= w.reg_value;
          opcode_i <= w.opcode;
          thumb_i <= w.thumb;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off so the block backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cycles <= 0;
      hold_started <= 1'b0;
    end else if (!hold_started && words_taken >= HOLD_AT) begin
      hold_cycles <= HOLD_LEN;
      hold_started <= 1'b1;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap <= 0;
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      recv_gap <= $urandom_range(0, 12);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (hold_cycles != 0);
    end
  end

  always @(posedge clk_i) begin : check_proc
    fault_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        log_mismatch($sformatf("unexpected word addr=%08h matched=%0b",
                               fault_address_o, matched_o));
      end else begin
        want = expected_results.pop_front();
        if (fault_address_o !== want.addr || matched_o !== want.matched)
          log_mismatch($sformatf("addr exp=%08h got=%08h matched exp=%0b got=%0b",
                                 want.addr, fault_address_o, want.matched, matched_o));
      end
    end
  end

  initial begin : stimulus
    logic [31:0] r;
    logic [31:0] op;
    logic [15:0] t;
    logic [31:0] v;
    logic        th;
    foreach (shadow_regs[i]) shadow_regs[i] = 32'd0;

    // directed: extreme register contents and each decode form
    queue_write(4'd1, 32'hFFFF_FFFF);
    queue_write(4'd2, 32'h8000_0000);
    queue_write(4'd3, 32'd33);
    queue_write(REG_SP, 32'h0000_1000);
    queue_write(REG_PC, 32'hFFFF_FF00);
    queue_resolve(32'hE101_2092, 1'b0);   // swp wins over halfword register form
    queue_resolve(32'hE491_2004, 1'b0);   // post-index
    queue_resolve(32'hE591_2FFF, 1'b0);   // immediate add, wraps
    queue_resolve(32'hE511_2004, 1'b0);   // immediate subtract
    queue_resolve(32'hE791_20B2, 1'b0);   // register offset taken unshifted
    queue_resolve(32'hE791_2F82, 1'b0);   // lsl #31
    queue_resolve(32'hE791_2352, 1'b0);   // asr by register holding 33
    queue_resolve(32'hE791_2332, 1'b0);   // lsr by register holding 33
    queue_resolve(32'hE711_2062, 1'b0);   // ror #0 leaves value alone
    queue_resolve(32'hE191_20B2, 1'b0);   // halfword register
    queue_resolve(32'hE1D1_20BF, 1'b0);   // halfword immediate
    queue_resolve(32'hE8BD_00FF, 1'b0);   // ldm
    queue_resolve(32'hED91_2000, 1'b0);   // no pattern
    queue_resolve(32'h0000_48FF, 1'b1);   // pc-relative, negative byte
    queue_resolve(32'hFFFF_5888, 1'b1);   // register form
    queue_resolve(32'h0000_5E88, 1'b1);   // ldrsh register form
    queue_resolve(32'h0000_6FC8, 1'b1);   // word immediate
    queue_resolve(32'h0000_8FC8, 1'b1);   // halfword immediate
    queue_resolve(32'h0000_9880, 1'b1);   // sp-relative
    queue_resolve(32'h0000_BDFF, 1'b1);   // pop
    queue_resolve(32'h0000_CF00, 1'b1);   // ldm
    queue_resolve(32'hFFFF_0000, 1'b1);   // no pattern

    // random: mostly well-formed load/store words with random contents
    repeat (RANDOM_WORDS) begin
      r = $urandom;
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0, 1: v = $urandom_range(0, 40);
          2:    v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
          default: v = $urandom;
        endcase
        queue_write(4'($urandom_range(0, 15)), v);
      end else begin
        th = 1'($urandom_range(0, 1));
        t = r[15:0];
        op = r;
        if (th) begin
          case ($urandom_range(0, 9))
            0: t = TH_LDR_PC | (t & ~TH_F800_MASK);
            1: t = TH_REG_A | (t & ~TH_F000_MASK);
            2: t = TH_IMM_A | (t & ~TH_E000_MASK);
            3: t = TH_IMM_B | (t & ~TH_F000_MASK);
            4: t = TH_SP_REL | (t & ~TH_F000_MASK);
            5: t = TH_PUSH_POP | (t & ~TH_F700_MASK);
            6: t = TH_LDM_STM | (t & ~TH_F000_MASK);
            default: ;
          endcase
          op = {16'($urandom_range(0, 16'hFFFF)), t};
        end else begin
          case ($urandom_range(0, 9))
            0: op = ARM_SWP_VAL | (r & ~ARM_SWP_MASK);
            1: op = ARM_LS_VAL | (r & ~ARM_LS_MASK);
            2: op = ARM_LS_VAL | (r & ~ARM_LS_MASK) | 32'h0300_0000;
            3: begin
              op = ARM_LS_VAL | (r & ~ARM_LS_MASK) | 32'h0300_0000;
              op[11:4] = SHIFT_NONE;
            end
            4: op = ARM_HWR_VAL | (r & ~ARM_HW_MASK);
            5: op = ARM_HWI_VAL | (r & ~ARM_HW_MASK);
            6: op = ARM_LSM_VAL | (r & ~ARM_LSM_MASK);
            default: ;
          endcase
        end
        queue_resolve(op, th);
      end
    end
    quiet_from = pending_words.size() - QUIET_TAIL;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_words.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 12);
    $display("testbench: FAIL");
    $finish;
  end

endmodule
